>>> hw/rtl/chf_pkg.sv
// ----------------------------------------------------------------------------
// chf_pkg: shared types and constants for the chained hash find-or-insert block
// Holds the controller state type, the command and status bundles, and the
// default sizes and field widths.
// ----------------------------------------------------------------------------
package chf_pkg;

	localparam int BUCKETS_DEF  = 256;
	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_BITS_DEF = 64;

	localparam int KEY_W       = 64;
	localparam int SLOT_W      = 10;
	localparam int OUT_DATA_W  = 16;
	localparam int OUT_USER_W  = 2;
	localparam int FOLD_W      = 16;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_HEAD_RD,
		ST_HEAD_CHK,
		ST_WALK,
		ST_INSERT,
		ST_DONE
	} chf_state_t;

	typedef struct packed {
		logic clr_step;
		logic load_key;
		logic hash_step;
		logic head_rd;
		logic rd_head;
		logic rd_next;
		logic res_hit;
		logic res_full;
		logic insert;
		logic out_load;
	} chf_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_last;
		logic head_nil;
		logic key_hit;
		logic next_nil;
		logic full;
		logic out_free;
	} chf_sts_t;

endpackage

>>> hw/rtl/chained_hash_find_or_insert.sv
// ----------------------------------------------------------------------------
// chained_hash_find_or_insert: hash table find-or-insert with chained buckets
// Finds a key by walking its bucket chain, or stores it in the next free slot
// at the head of the chain, and returns the slot.
//
//   Channel   Dir  Payload
//   s_axis    in   tdata[63:0] key
//   m_axis    out  tdata[9:0] slot, tuser[0] was_present, tuser[1] table_full
//
// The chain walk reads one slot memory entry a cycle. After reset the bucket
// heads are cleared one per cycle, and no request is accepted until all of
// them are cleared. One request is worked on at a time; a result waits in the
// output register while the next request is taken.
// ----------------------------------------------------------------------------
module chained_hash_find_or_insert #(
	parameter int BUCKETS  = chf_pkg::BUCKETS_DEF,
	parameter int CAPACITY = chf_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = chf_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [chf_pkg::KEY_W-1:0]      s_axis_tdata,   // key
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [chf_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // slot
	output logic [chf_pkg::OUT_USER_W-1:0] m_axis_tuser    // was_present, table_full
);
	import chf_pkg::*;

	chf_cmd_t cmd;
	chf_sts_t sts;

	chf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	chf_dp #(
		.BUCKETS  (BUCKETS),
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_key    (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

>>> hw/rtl/chf_ctrl.sv
// ----------------------------------------------------------------------------
// chf_ctrl: sequencer of the chained hash find-or-insert block
// Clears the bucket heads after reset, then steps each request through hash,
// head read, chain walk, insertion and result hand-off.
// ----------------------------------------------------------------------------
module chf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  chf_pkg::chf_sts_t sts,
	output chf_pkg::chf_cmd_t cmd
);
	import chf_pkg::*;

	chf_state_t state_q;
	chf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_HASH;
			end
			ST_HASH: begin
				if (sts.hash_last) state_d = ST_HEAD_RD;
			end
			ST_HEAD_RD: begin
				state_d = ST_HEAD_CHK;
			end
			ST_HEAD_CHK: begin
				state_d = sts.head_nil ? ST_INSERT : ST_WALK;
			end
			ST_WALK: begin
				if (sts.key_hit) state_d = ST_DONE;
				else if (sts.next_nil) state_d = ST_INSERT;
			end
			ST_INSERT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_key = in_valid;
			end
			ST_HASH: begin
				cmd.hash_step = 1'b1;
			end
			ST_HEAD_RD: begin
				cmd.head_rd = 1'b1;
			end
			ST_HEAD_CHK: begin
				cmd.rd_head = !sts.head_nil;
			end
			ST_WALK: begin
				cmd.res_hit = sts.key_hit;
				cmd.rd_next = !sts.key_hit && !sts.next_nil;
			end
			ST_INSERT: begin
				cmd.res_full = sts.full;
				cmd.insert   = !sts.full;
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hw/rtl/chf_dp.sv
// ----------------------------------------------------------------------------
// chf_dp: datapath of the chained hash find-or-insert block
// Key folding and bucket remainder unit, bucket head memory, slot key and
// link memories, allocation counter and the output register.
// ----------------------------------------------------------------------------
module chf_dp #(
	parameter int BUCKETS  = chf_pkg::BUCKETS_DEF,
	parameter int CAPACITY = chf_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = chf_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [chf_pkg::KEY_W-1:0]      in_key,
	input  chf_pkg::chf_cmd_t              cmd,
	output chf_pkg::chf_sts_t              sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [chf_pkg::OUT_DATA_W-1:0] out_data,
	output logic [chf_pkg::OUT_USER_W-1:0] out_user
);
	import chf_pkg::*;

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int SHIFT = FOLD_W + BW;
	localparam int PW = 2 * FOLD_W + 1;
	localparam logic [FOLD_W:0] RECIP =
		(FOLD_W + 1)'(((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
	localparam logic [PW-1:0] BUCK_P   = PW'(BUCKETS);
	localparam logic [BW-1:0] BUCK_TOP = BW'(BUCKETS - 1);
	localparam logic [LW-1:0] NIL      = LW'(CAPACITY);

	logic [LW-1:0]       head_mem [BUCKETS];
	logic [KEY_BITS-1:0] key_mem  [CAPACITY];
	logic [LW-1:0]       next_mem [CAPACITY];

	logic [BW-1:0]       clr_q;
	logic                hash_cnt_q;
	logic [LW-1:0]       used_q;
	logic                out_valid_q;

	logic [KEY_BITS-1:0] key_q;
	logic [FOLD_W-1:0]   fold_q;
	logic [FOLD_W-1:0]   quot_q;
	logic [BW-1:0]       rem_q;
	logic [LW-1:0]       head_rd_q;
	logic [KEY_BITS-1:0] key_rd_q;
	logic [LW-1:0]       next_rd_q;
	logic [LW-1:0]       cur_q;
	logic [LW-1:0]       res_slot_q;
	logic                res_present_q;
	logic                res_full_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_present_q;
	logic                out_full_q;

	logic [KEY_W-1:0]    key_ext;
	logic [FOLD_W-1:0]   fold_in;
	logic [PW-1:0]       prod;
	logic [FOLD_W-1:0]   quot_v;
	logic [PW-1:0]       rem_full;
	logic [LW-1:0]       slot_addr;
	logic                slot_rd;
	logic                head_we;
	logic [BW-1:0]       head_waddr;
	logic [LW-1:0]       head_wdata;
	logic [31:0]         slot_wide;

	assign key_ext = KEY_W'(in_key[KEY_BITS-1:0]);
	assign fold_in = key_ext[15:0] ^ key_ext[31:16] ^ key_ext[47:32] ^ key_ext[63:48];

	// The quotient by the bucket count comes from a reciprocal multiplication
	// in the first hash step, the remainder from a multiply-back in the second.
	assign prod     = PW'(fold_q) * PW'(RECIP);
	assign quot_v   = FOLD_W'(prod >> SHIFT);
	assign rem_full = PW'(fold_q) - PW'(quot_q) * BUCK_P;

	assign slot_rd   = cmd.rd_head || cmd.rd_next;
	assign slot_addr = cmd.rd_head ? head_rd_q : next_rd_q;

	assign head_we    = cmd.clr_step || cmd.insert;
	assign head_waddr = cmd.clr_step ? clr_q : rem_q;
	assign head_wdata = cmd.clr_step ? NIL : used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			hash_cnt_q  <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + BW'(1);
			if (cmd.load_key) hash_cnt_q <= 1'b0;
			else if (cmd.hash_step) hash_cnt_q <= ~hash_cnt_q;
			if (cmd.insert) used_q <= used_q + LW'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q  <= in_key[KEY_BITS-1:0];
			fold_q <= fold_in;
			rem_q  <= '0;
		end else if (cmd.hash_step) begin
			if (!hash_cnt_q) quot_q <= quot_v;
			else rem_q <= rem_full[BW-1:0];
		end
		if (cmd.head_rd) head_rd_q <= head_mem[rem_q];
		if (head_we) head_mem[head_waddr] <= head_wdata;
	end

	always_ff @(posedge clk) begin
		if (slot_rd) begin
			key_rd_q  <= key_mem[slot_addr[SW-1:0]];
			next_rd_q <= next_mem[slot_addr[SW-1:0]];
			cur_q     <= slot_addr;
		end
		if (cmd.insert) begin
			key_mem[used_q[SW-1:0]]  <= key_q;
			next_mem[used_q[SW-1:0]] <= head_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_hit) begin
			res_slot_q    <= cur_q;
			res_present_q <= 1'b1;
			res_full_q    <= 1'b0;
		end else if (cmd.res_full) begin
			res_slot_q    <= '0;
			res_present_q <= 1'b0;
			res_full_q    <= 1'b1;
		end else if (cmd.insert) begin
			res_slot_q    <= used_q;
			res_present_q <= 1'b0;
			res_full_q    <= 1'b0;
		end
		if (cmd.out_load) begin
			out_slot_q    <= slot_wide[SLOT_W-1:0];
			out_present_q <= res_present_q;
			out_full_q    <= res_full_q;
		end
	end

	assign slot_wide = 32'(res_slot_q);

	assign sts.clr_last  = (clr_q == BUCK_TOP);
	assign sts.hash_last = hash_cnt_q;
	assign sts.head_nil  = (head_rd_q >= NIL);
	assign sts.key_hit   = (key_rd_q == key_q);
	assign sts.next_nil  = (next_rd_q >= NIL);
	assign sts.full      = (used_q >= NIL);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = OUT_DATA_W'(out_slot_q);
	assign out_user  = {out_full_q, out_present_q};

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= NIL)
		else $error("allocation count above capacity");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> used_q == $past(used_q) + LW'(1))
		else $error("insert did not advance allocation count");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !sts.full)
		else $error("insert issued with table full");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an unaccepted result");

endmodule

>>> dv/chained_hash_find_or_insert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_find_or_insert_test: self-checking bench for the hash table
// Sends 64-bit keys and checks each returned slot, hit flag and full flag
// against a local copy of the chained table. Covers extreme and colliding
// keys, output stalls, filling the table to capacity, and requests that
// arrive after the table is full.
// ----------------------------------------------------------------------------
module chained_hash_find_or_insert_test;

	localparam int BUCKETS      = chf_pkg::BUCKETS_DEF;
	localparam int CAPACITY     = chf_pkg::CAPACITY_DEF;
	localparam int KEY_BITS     = chf_pkg::KEY_BITS_DEF;
	localparam int SLOT_W       = chf_pkg::SLOT_W;
	localparam int PRESENT_BIT  = 0;
	localparam int FULL_BIT     = 1;
	localparam int DRAIN_CYCLES = 80;
	localparam int RUN_LIMIT_NS = 6_000_000;
	localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              was_present;
		logic              table_full;
	} slot_answer_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [chf_pkg::KEY_W-1:0]      s_axis_tdata;   // key
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [chf_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // slot
	logic [chf_pkg::OUT_USER_W-1:0] m_axis_tuser;   // was_present, table_full

	int           head_of_bucket[BUCKETS];
	logic [63:0]  key_in_slot[CAPACITY];
	int           link_of_slot[CAPACITY];
	int           slots_taken;
	slot_answer_t slot_answers_due[$];

	int error_count;
	int hold_left;
	bit sender_steady;
	bit receiver_steady;

	chained_hash_find_or_insert dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	function automatic int bucket_of(input logic [63:0] k);
		logic [15:0] folded;
		folded = k[15:0] ^ k[31:16] ^ k[47:32] ^ k[63:48];
		return int'(folded) % BUCKETS;
	endfunction

	// Finds the key in the local table or inserts it, as the block must.
	function automatic slot_answer_t lookup_slot(input logic [63:0] raw_key);
		logic [63:0]  k;
		int           b;
		int           cur;
		int           steps;
		slot_answer_t ans;
		k = raw_key & KEY_MASK;
		b = bucket_of(k);
		cur = head_of_bucket[b];
		steps = 0;
		ans = '0;
		while (cur < CAPACITY && steps < CAPACITY) begin
			if (key_in_slot[cur] == k) begin
				ans.slot = SLOT_W'(cur);
				ans.was_present = 1'b1;
				return ans;
			end
			cur = link_of_slot[cur];
			steps++;
		end
		if (slots_taken >= CAPACITY) begin
			ans.table_full = 1'b1;
			return ans;
		end
		key_in_slot[slots_taken] = k;
		link_of_slot[slots_taken] = head_of_bucket[b];
		head_of_bucket[b] = slots_taken;
		ans.slot = SLOT_W'(slots_taken);
		slots_taken++;
		return ans;
	endfunction

	// The low piece is chosen so that the folded key lands in bucket b.
	function automatic logic [63:0] key_for_bucket(input int b);
		logic [63:0] k;
		logic [15:0] want;
		k = {$urandom, $urandom};
		want = 16'(b + BUCKETS * $urandom_range(0, (65535 - b) / BUCKETS));
		k[15:0] = k[31:16] ^ k[47:32] ^ k[63:48] ^ want;
		return k;
	endfunction

	function automatic int hot_bucket();
		return ($urandom_range(0, 3) * 84 + 3) % BUCKETS;
	endfunction

	function automatic logic [63:0] stored_key();
		return key_in_slot[$urandom_range(0, slots_taken - 1)];
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic send_key(input logic [63:0] key);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= key;
		do @(posedge clk); while (!s_axis_tready);
		slot_answers_due.push_back(lookup_slot(key));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (slot_answers_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: random stalls, long holds on request, and the checks.
	initial begin
		int           stall;
		slot_answer_t want;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_left) @(posedge clk);
				hold_left = 0;
			end
			stall = receiver_steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid && hold_left == 0);
			if (m_axis_tvalid) begin
				if (slot_answers_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: slot %0h user %b",
						m_axis_tdata, m_axis_tuser));
				end else begin
					want = slot_answers_due.pop_front();
					if (m_axis_tdata !== chf_pkg::OUT_DATA_W'(want.slot))
						report_mismatch($sformatf("slot is %0h, expected %0h",
							m_axis_tdata, want.slot));
					if (m_axis_tuser[PRESENT_BIT] !== want.was_present)
						report_mismatch($sformatf("was_present is %b, expected %b",
							m_axis_tuser[PRESENT_BIT], want.was_present));
					if (m_axis_tuser[FULL_BIT] !== want.table_full)
						report_mismatch($sformatf("table_full is %b, expected %b",
							m_axis_tuser[FULL_BIT], want.table_full));
				end
			end
		end
	end

	// Zero, all ones and keys that fold alike share buckets, several of them bucket zero.
	task automatic test_directed_extremes();
		send_key(64'h0000_0000_0000_0000);
		send_key(64'hFFFF_FFFF_FFFF_FFFF);
		send_key(64'h0000_0000_0000_0000);
		send_key(64'hFFFF_FFFF_FFFF_FFFF);
		send_key(64'h0001_0002_0003_0004);
		send_key(64'h0004_0003_0002_0001);
		send_key(64'h8000_0000_0000_8000);
		send_key(64'h0000_0000_0000_0001);
		send_key(64'h8000_0000_0000_0000);
		send_key(64'h0001_0002_0003_0004);
		drain_results();
	endtask

	// Builds one long chain and hits every link of it.
	task automatic test_chain_collisions();
		logic [63:0] keys[6];
		int i;
		for (i = 0; i < 6; i++) begin
			keys[i] = key_for_bucket(200);
			send_key(keys[i]);
		end
		for (i = 0; i < 6; i++)
			send_key(keys[i]);
		drain_results();
	endtask

	// The result side holds off while requests keep coming.
	task automatic test_output_backpressure();
		int i;
		hold_left = 300;
		sender_steady = 1'b1;
		for (i = 0; i < 24; i++) begin
			if (i % 3 == 2)
				send_key(stored_key());
			else
				send_key({$urandom, $urandom});
		end
		sender_steady = 1'b0;
		drain_results();
	endtask

	task automatic test_fill_table();
		int n;
		int r;
		logic [63:0] k;
		n = 0;
		while (slots_taken < CAPACITY) begin
			sender_steady   = (n >= 400 && n < 500);
			receiver_steady = sender_steady;
			if (n % 250 == 249)
				drain_results();
			r = $urandom_range(0, 99);
			if (r < 30)
				k = stored_key();
			else if (r < 40)
				k = key_for_bucket(hot_bucket());
			else
				k = {$urandom, $urandom};
			send_key(k);
			n++;
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
		drain_results();
	endtask

	// Misses are refused once the table is full, while hits still succeed.
	task automatic test_full_table();
		int n;
		int r;
		logic [63:0] k;
		send_key(64'h0000_0000_0000_0000);
		send_key(64'hFFFF_FFFF_FFFF_FFFF);
		for (n = 0; n < 280; n++) begin
			if (n == 140)
				drain_results();
			r = $urandom_range(0, 99);
			if (r < 45)
				k = stored_key();
			else if (r < 55)
				k = key_for_bucket(hot_bucket());
			else
				k = {$urandom, $urandom};
			send_key(k);
		end
		drain_results();
	endtask

	initial begin
		int i;
		error_count     = 0;
		hold_left       = 0;
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
		slots_taken     = 0;
		for (i = 0; i < BUCKETS; i++)
			head_of_bucket[i] = CAPACITY;
		for (i = 0; i < CAPACITY; i++) begin
			key_in_slot[i]  = '0;
			link_of_slot[i] = CAPACITY;
		end
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_chain_collisions();
		test_output_backpressure();
		test_fill_table();
		test_full_table();

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
